// ----- design/gdd_pkg.sv -----
// Shared constants, types and calendar tables for the date difference block.
package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MD_W    = 7;
    localparam int DAYS_W  = 22;
    localparam int COUNT_W = 24;
    localparam int Y365_W  = 23;
    localparam int MIDX_W  = 4;
    localparam int MBASE_W = 9;
    localparam int MLEN_W  = 5;

    localparam int EPOCH_YEAR_DEF = 2000;

    // x / 25 == (x * RECIP25) >> RECIP_SHIFT for x below 4096
    localparam int RECIP25     = 41944;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 16;
    localparam int DIV_BY      = 25;

    localparam int DAYS_PER_YEAR = 365;

    localparam logic [DAYS_W-1:0] DAYS_MAX = {DAYS_W{1'b1}};

    localparam logic [MIDX_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MIDX_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MIDX_W-1:0] MONTH_MAR   = 4'd3;
    localparam logic [MIDX_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [MIDX_W-1:0] MONTH_CLAMP = 4'd13;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    function automatic logic [MBASE_W-1:0] month_start(input logic [MIDX_W-1:0] m);
        logic [MBASE_W-1:0] r;
        unique case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            4'd13:   r = 9'd365;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [MLEN_W-1:0] month_len(input logic [MIDX_W-1:0] m,
                                                    input logic leap);
        logic [MLEN_W-1:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/gdd_day_count.sv -----
// Three-stage lane turning one date into a signed day count and a validity flag.
module gdd_day_count #(
    parameter int EPOCH_YEAR = gdd_pkg::EPOCH_YEAR_DEF
) (
    input  logic                               clk,
    input  gdd_pkg::stage_en_t                 en,
    input  logic [gdd_pkg::YEAR_W-1:0]         year,
    input  logic [gdd_pkg::MD_W-1:0]           month,
    input  logic [gdd_pkg::MD_W-1:0]           day,
    output logic signed [gdd_pkg::COUNT_W-1:0] count,
    output logic                               valid
);

    localparam int YW  = gdd_pkg::YEAR_W;
    localparam int Q4W = YW - 2;
    localparam int Q16W = YW - 4;
    localparam int P100W = Q4W + gdd_pkg::RECIP_W;
    localparam int P400W = Q16W + gdd_pkg::RECIP_W;
    localparam int Q100W = P100W - gdd_pkg::RECIP_SHIFT;
    localparam int Q400W = P400W - gdd_pkg::RECIP_SHIFT;
    localparam int Y365W = gdd_pkg::Y365_W;
    localparam int CW = gdd_pkg::COUNT_W;
    localparam int LEAPS_BEFORE = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                                + (EPOCH_YEAR - 1) / 400;
    localparam logic [YW-1:0] EPOCH = YW'(EPOCH_YEAR);

    // stage 1
    logic [YW-1:0]                  ym1_reg, ym1_next;
    logic [3:0]                     ylow_reg, ylow_next;
    logic                           yzero_reg, yzero_next;
    logic                           ygt1_reg, ygt1_next;
    logic [Q100W-1:0]               q100_reg, q100_next;
    logic [Q400W-1:0]               q400_reg, q400_next;
    logic [Y365W-1:0]               y365_reg, y365_next;
    logic [gdd_pkg::MIDX_W-1:0]     m1_reg, m1_next;
    logic [gdd_pkg::MD_W-1:0]       d1_reg, d1_next;

    // stage 2
    logic [Y365W-1:0]               ypart_reg, ypart_next;
    logic                           leap_reg, leap_next;
    logic [gdd_pkg::MIDX_W-1:0]     m2_reg, m2_next;
    logic [gdd_pkg::MD_W-1:0]       d2_reg, d2_next;
    logic                           ok2_reg, ok2_next;

    // stage 3
    logic signed [CW-1:0]           count_reg, count_next;
    logic                           valid_reg, valid_next;

    logic [P100W-1:0]               p100;
    logic [P400W-1:0]               p400;
    logic [Q4W-1:0]                 r100;
    logic [Q16W-1:0]                r400;
    logic [Q4W-1:0]                 lcnt;
    logic                           c100;
    logic                           c400;
    logic [gdd_pkg::MLEN_W-1:0]     mlen;
    logic [CW-1:0]                  sum;

    always_comb
    begin
        ym1_next   = year - YW'(1);
        ylow_next  = year[3:0];
        yzero_next = (year == '0);
        ygt1_next  = (year > EPOCH);
        p100       = P100W'(ym1_next[YW-1:2]) * P100W'(gdd_pkg::RECIP25);
        p400       = P400W'(ym1_next[YW-1:4]) * P400W'(gdd_pkg::RECIP25);
        q100_next  = p100[P100W-1:gdd_pkg::RECIP_SHIFT];
        q400_next  = p400[P400W-1:gdd_pkg::RECIP_SHIFT];
        y365_next  = ygt1_next
                   ? Y365W'(year - EPOCH) * Y365W'(gdd_pkg::DAYS_PER_YEAR)
                   : '0;
        m1_next    = (month > gdd_pkg::MD_W'(gdd_pkg::MONTH_CLAMP))
                   ? gdd_pkg::MONTH_CLAMP : month[gdd_pkg::MIDX_W-1:0];
        d1_next    = day;
    end

    always_comb
    begin
        r100  = ym1_reg[YW-1:2] - Q4W'(q100_reg) * Q4W'(gdd_pkg::DIV_BY);
        r400  = ym1_reg[YW-1:4] - Q16W'(q400_reg) * Q16W'(gdd_pkg::DIV_BY);
        c100  = (ylow_reg[1:0] == 2'b00) && (r100 == Q4W'(gdd_pkg::DIV_BY - 1));
        c400  = (ylow_reg == 4'b0000) && (r400 == Q16W'(gdd_pkg::DIV_BY - 1));
        leap_next = yzero_reg || ((ylow_reg[1:0] == 2'b00) && !c100) || c400;
        lcnt  = ym1_reg[YW-1:2] - Q4W'(q100_reg) + Q4W'(q400_reg);
        ypart_next = ygt1_reg
                   ? y365_reg + Y365W'(lcnt) - Y365W'(LEAPS_BEFORE)
                   : '0;
        mlen  = gdd_pkg::month_len(m1_reg, leap_next);
        ok2_next = (d1_reg != '0) && (d1_reg <= gdd_pkg::MD_W'(mlen));
        m2_next = m1_reg;
        d2_next = d1_reg;
    end

    always_comb
    begin
        sum = CW'(ypart_reg) + CW'(gdd_pkg::month_start(m2_reg))
            + CW'((m2_reg >= gdd_pkg::MONTH_MAR) && leap_reg) + CW'(d2_reg);
        count_next = $signed(sum - CW'(1));
        valid_next = ok2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ym1_reg   <= ym1_next;
            ylow_reg  <= ylow_next;
            yzero_reg <= yzero_next;
            ygt1_reg  <= ygt1_next;
            q100_reg  <= q100_next;
            q400_reg  <= q400_next;
            y365_reg  <= y365_next;
            m1_reg    <= m1_next;
            d1_reg    <= d1_next;
        end
        if (en.s2)
        begin
            ypart_reg <= ypart_next;
            leap_reg  <= leap_next;
            m2_reg    <= m2_next;
            d2_reg    <= d2_next;
            ok2_reg   <= ok2_next;
        end
        if (en.s3)
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    assign count = count_reg;
    assign valid = valid_reg;

endmodule

// ----- design/gregorian_date_difference.sv -----
// Top level: two day-count lanes, difference stage and pipeline handshake.
// Each request carries two dates and yields one result; a new request can
// enter every cycle while in_stall is low. The four register
// stages are: reciprocal multiply for the year divisions, leap rule and
// year offset, month/day summation, and the absolute difference with
// saturation. A stalled output holds only the stages that are full; empty
// stages behind it keep filling.
module gregorian_date_difference #(
    parameter int EPOCH_YEAR = gdd_pkg::EPOCH_YEAR_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [gdd_pkg::YEAR_W-1:0]  first_year,
    input  logic [gdd_pkg::MD_W-1:0]    first_month,
    input  logic [gdd_pkg::MD_W-1:0]    first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]  second_year,
    input  logic [gdd_pkg::MD_W-1:0]    second_month,
    input  logic [gdd_pkg::MD_W-1:0]    second_day,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gdd_pkg::DAYS_W-1:0]  days_between,
    output logic                        first_valid,
    output logic                        second_valid
);

    localparam int CW = gdd_pkg::COUNT_W;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic v4_reg, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    gdd_pkg::stage_en_t en;

    logic signed [CW-1:0] cnt_a;
    logic signed [CW-1:0] cnt_b;
    logic                 ok_a;
    logic                 ok_b;
    logic [CW-1:0]        diff;

    logic [gdd_pkg::DAYS_W-1:0] days_reg, days_next;
    logic                       fv_reg, fv_next;
    logic                       sv_reg, sv_next;

    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;

    assign in_stall = !rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;
    assign v4_next = rdy4 ? v3_reg   : v4_reg;

    gdd_day_count #(.EPOCH_YEAR(EPOCH_YEAR)) u_first (
        .clk   (clk),
        .en    (en),
        .year  (first_year),
        .month (first_month),
        .day   (first_day),
        .count (cnt_a),
        .valid (ok_a)
    );

    gdd_day_count #(.EPOCH_YEAR(EPOCH_YEAR)) u_second (
        .clk   (clk),
        .en    (en),
        .year  (second_year),
        .month (second_month),
        .day   (second_day),
        .count (cnt_b),
        .valid (ok_b)
    );

    always_comb
    begin
        diff = (cnt_a > cnt_b) ? CW'(cnt_a - cnt_b) : CW'(cnt_b - cnt_a);
        days_next = (diff > CW'(gdd_pkg::DAYS_MAX))
                  ? gdd_pkg::DAYS_MAX : diff[gdd_pkg::DAYS_W-1:0];
        fv_next = ok_a;
        sv_next = ok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            days_reg <= days_next;
            fv_reg   <= fv_next;
            sv_reg   <= sv_next;
        end
    end

    assign out_valid    = v4_reg;
    assign days_between = days_reg;
    assign first_valid  = fv_reg;
    assign second_valid = sv_reg;

`ifndef SYNTHESIS
    // accepted request lands in stage one
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted request not captured in stage one");

    // empty pipeline never pushes back
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> !in_stall)
        else $error("input stalled with empty pipeline");

    // full stage behind a stalled output is held
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && out_stall && v3_reg) |=> (v3_reg && v4_reg))
        else $error("stage three request lost under output stall");
`endif

endmodule
